@@ rtl/core/dopm_pkg.sv @@
// Shared types, constants and elaboration-time table generators for the
// dual oscillator mixer. Used by every module in rtl/core.
package dopm_pkg;

	localparam int PH_W       = 24;
	localparam int WT_SIZE    = 64;
	localparam int WT_IDX_W   = $clog2(WT_SIZE);
	localparam int SINE_DEPTH = 1024;
	localparam int SINE_IDX_W = $clog2(SINE_DEPTH);
	localparam int INC_MIN    = 3495;
	localparam int INC_MAX    = 6990507;

	localparam int SAMPLE_W   = 16;
	localparam int GAIN_W     = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam int MUL_A_W = 34;
	localparam int MUL_B_W = 25;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;
	localparam int DIV_Q_W = 17;

	localparam logic [CFG_IDX_W-1:0] CFG_INC_A    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INC_B    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FM_DEPTH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WAVE_A   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_WAVE_B   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_A  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_B  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SUB_GAIN = 3'd7;

	localparam logic [1:0] WAVE_A_TABLE  = 2'd0;
	localparam logic [1:0] WAVE_A_SAW    = 2'd1;
	localparam logic [1:0] WAVE_A_SQUARE = 2'd2;
	localparam logic [1:0] WAVE_B_SAW    = 2'd0;
	localparam logic [1:0] WAVE_B_SQUARE = 2'd1;
	localparam logic [1:0] WAVE_B_SINE   = 2'd2;

	typedef enum logic [2:0] {
		KIND_TABLE,
		KIND_SAW,
		KIND_SQUARE,
		KIND_SINE,
		KIND_ZERO
	} wave_kind_t;

	typedef logic [SINE_DEPTH-1:0][SAMPLE_W-1:0] sine_rom_t;
	typedef logic [WT_SIZE-1:0][SAMPLE_W-1:0] harm_table_t;

	localparam logic [63:0] Q30_ONE    = 64'd1073741824;
	localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

	// Sine of p/2^32 of a cycle in Q2.30, Taylor series on a folded quarter wave.
	function automatic logic signed [63:0] sin_q30(input logic [63:0] p_in);
		logic [63:0] p;
		logic [63:0] th;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] q;
		logic        neg;
		p = p_in & 64'hFFFF_FFFF;
		neg = 1'b0;
		if (p >= 64'h8000_0000) begin
			neg = 1'b1;
			p = p - 64'h8000_0000;
		end
		if (p > 64'h4000_0000) begin
			p = 64'h8000_0000 - p;
		end
		th = (p * TWO_PI_Q30) >> 32;
		x2 = (th * th) >> 30;
		t = Q30_ONE;
		for (int k = 0; k < 5; k++) begin
			q = (x2 * t) >> 30;
			case (k)
				0: q = q / 110;
				1: q = q / 72;
				2: q = q / 42;
				3: q = q / 20;
				default: q = q / 6;
			endcase
			t = Q30_ONE - q;
		end
		th = (th * t) >> 30;
		return neg ? -$signed(th) : $signed(th);
	endfunction

	function automatic logic [SAMPLE_W-1:0] q30_to_q15(input logic signed [63:0] v);
		logic [63:0]               m;
		logic signed [SAMPLE_W-1:0] r;
		m = (v < 0) ? 64'(-v) : 64'(v);
		m = (m + 64'd16384) >> 15;
		if (m > 64'd32767) begin
			m = 64'd32767;
		end
		r = $signed({1'b0, m[SAMPLE_W-2:0]});
		return (v < 0) ? -r : r;
	endfunction

	function automatic sine_rom_t gen_sine_rom();
		sine_rom_t r;
		for (int n = 0; n < SINE_DEPTH; n++) begin
			r[n] = q30_to_q15(sin_q30(64'(n) << (32 - SINE_IDX_W)));
		end
		return r;
	endfunction

	function automatic harm_table_t gen_harm_table();
		harm_table_t         r;
		logic signed [63:0]  acc;
		logic signed [63:0]  s;
		logic [63:0]         p;
		for (int n = 0; n < WT_SIZE; n++) begin
			acc = 64'sd0;
			for (int k = 0; k < 4; k++) begin
				p = 64'(((2 * k + 1) * n) % WT_SIZE) << (32 - WT_IDX_W);
				s = sin_q30(p);
				case (k)
					0: acc = acc + s;
					1: acc = acc + s / 2;
					2: acc = acc + s / 4;
					default: acc = acc + s / 8;
				endcase
			end
			r[n] = q30_to_q15(acc * 3 / 5);
		end
		return r;
	endfunction

	localparam sine_rom_t   SINE_ROM   = gen_sine_rom();
	localparam harm_table_t HARM_TABLE = gen_harm_table();

	function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [39:0] v);
		if (v > 40'sd32767) begin
			return 16'sh7FFF;
		end
		if (v < -40'sd32768) begin
			return 16'sh8000;
		end
		return v[SAMPLE_W-1:0];
	endfunction

endpackage

@@ rtl/core/dopm_mul.sv @@
// Shared signed multiplier with a registered product.
// Depends on dopm_pkg for operand widths.
module dopm_mul (
	input  logic                                clk,
	input  logic signed [dopm_pkg::MUL_A_W-1:0] op_a,
	input  logic signed [dopm_pkg::MUL_B_W-1:0] op_b,
	output logic signed [dopm_pkg::MUL_P_W-1:0] prod_q
);
	import dopm_pkg::*;

	always_ff @(posedge clk) begin
		prod_q <= MUL_P_W'(op_a) * MUL_P_W'(op_b);
	end

endmodule

@@ rtl/core/dopm_div.sv @@
// Restoring divider, one quotient bit per cycle, for (num << 16) / den.
// The caller guarantees num < den. Depends on dopm_pkg.
module dopm_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [dopm_pkg::PH_W-1:0]        num,
	input  logic [dopm_pkg::PH_W-1:0]        den,
	output logic                             done,
	output logic [dopm_pkg::DIV_Q_W-1:0]     quot
);
	import dopm_pkg::*;

	localparam int CNT_W = $clog2(DIV_Q_W + 1);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [PH_W-1:0]    rem_q;
	logic [PH_W-1:0]    den_q;
	logic [DIV_Q_W-1:0] bits_q;
	logic [DIV_Q_W-1:0] quot_q;
	logic [PH_W:0]      trial;
	logic [PH_W:0]      diff;
	logic               ge;

	assign trial = {rem_q, bits_q[DIV_Q_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_Q_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= {1'b0, num[PH_W-1:1]};
			bits_q <= {num[0], {(DIV_Q_W-1){1'b0}}};
			den_q  <= den;
		end else if (busy_q) begin
			rem_q  <= ge ? diff[PH_W-1:0] : trial[PH_W-1:0];
			bits_q <= {bits_q[DIV_Q_W-2:0], 1'b0};
			quot_q <= {quot_q[DIV_Q_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

@@ rtl/core/dopm_sine_rom.sv @@
// Sine lookup with registered read data.
// Contents come from the generator in dopm_pkg.
module dopm_sine_rom (
	input  logic                                 clk,
	input  logic [dopm_pkg::SINE_IDX_W-1:0]      idx,
	output logic signed [dopm_pkg::SAMPLE_W-1:0] data_q
);
	import dopm_pkg::*;

	always_ff @(posedge clk) begin
		data_q <= $signed(SINE_ROM[idx]);
	end

endmodule

@@ rtl/core/dual_oscillator_polyblep_mixer.sv @@
// Top level: configuration registers, sequencer and datapath of the mixer.
// Uses dopm_pkg, dopm_mul, dopm_div and dopm_sine_rom.
//
//  channel   signals                               direction
//  input     in_valid, in_stall, fm_in             sample in
//  output    out_valid, out_stall, mix_out,        samples out
//            osc_a_out, osc_b_out
//  config    cfg_we, cfg_idx, cfg_data             register write
//
// Each accepted sample passes through FM scaling (ST_FM_MUL, ST_FM_F,
// ST_INCB_MUL and, for a positive factor, ST_INCB), both oscillators, the mix
// (ST_MIX_A to ST_MIX_END) and ST_OUT, then ST_IDLE. Sine and table waves use
// ST_SINE or ST_TBL_MUL and ST_TBL_FIN; each active polyBLEP correction waits
// on the shared divider, then runs ST_BLEP_MUL and ST_BLEP_ACC. Reset clears
// phases, config and sequencer state. in_stall is high while a sample is in
// work; a finished result waits in the output register while out_stall holds.
module dual_oscillator_polyblep_mixer (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic signed [dopm_pkg::SAMPLE_W-1:0]   fm_in,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [dopm_pkg::SAMPLE_W-1:0]   mix_out,
	output logic signed [dopm_pkg::SAMPLE_W-1:0]   osc_a_out,
	output logic signed [dopm_pkg::SAMPLE_W-1:0]   osc_b_out,
	input  logic                                   cfg_we,
	input  logic [dopm_pkg::CFG_IDX_W-1:0]         cfg_idx,
	input  logic [dopm_pkg::CFG_DATA_W-1:0]        cfg_data
);
	import dopm_pkg::*;

	typedef enum logic [18:0] {
		ST_IDLE     = 19'h00001,
		ST_FM_MUL   = 19'h00002,
		ST_FM_F     = 19'h00004,
		ST_INCB_MUL = 19'h00008,
		ST_INCB     = 19'h00010,
		ST_PH       = 19'h00020,
		ST_SINE     = 19'h00040,
		ST_TBL_MUL  = 19'h00080,
		ST_TBL_FIN  = 19'h00100,
		ST_BLEP     = 19'h00200,
		ST_DIV      = 19'h00400,
		ST_BLEP_MUL = 19'h00800,
		ST_BLEP_ACC = 19'h01000,
		ST_OSC_DONE = 19'h02000,
		ST_MIX_A    = 19'h04000,
		ST_MIX_B    = 19'h08000,
		ST_MIX_S    = 19'h10000,
		ST_MIX_END  = 19'h20000,
		ST_OUT      = 19'h40000
	} state_t;

	localparam logic [PH_W-1:0] PH_HALF  = {1'b1, {(PH_W-1){1'b0}}};
	localparam logic [PH_W:0]   PH_FULL  = {1'b1, {PH_W{1'b0}}};
	localparam logic [PH_W-1:0] INC_LO   = PH_W'(INC_MIN);
	localparam logic [PH_W-1:0] INC_HI   = PH_W'(INC_MAX);
	localparam logic [PH_W-1:0] INC_S_HI = PH_W'(INC_MAX / 2);
	localparam int ACC_W = 18;
	localparam int MIX_W = 36;

	state_t state_q;

	logic [PH_W-1:0]            inc_a_raw_q;
	logic [PH_W-1:0]            inc_b_raw_q;
	logic [GAIN_W-1:0]          fm_depth_q;
	logic [1:0]                 wave_a_q;
	logic [1:0]                 wave_b_q;
	logic [GAIN_W-1:0]          level_a_q;
	logic [GAIN_W-1:0]          level_b_q;
	logic [GAIN_W-1:0]          sub_gain_q;

	logic [PH_W-1:0]            phase_a_q;
	logic [PH_W-1:0]            phase_b_q;
	logic [PH_W-1:0]            phase_sub_q;
	logic [PH_W-1:0]            inc_b_q;
	logic signed [SAMPLE_W-1:0] fm_q;
	logic signed [MUL_A_W-1:0]  f_q;
	logic                       osc_sel_q;
	logic                       blep_idx_q;
	logic                       blep_negc_q;
	logic signed [ACC_W-1:0]    acc_q;
	logic signed [SAMPLE_W-1:0] a_q;
	logic signed [SAMPLE_W-1:0] b_q;
	logic signed [MIX_W-1:0]    mix_q;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] mix_out_q;
	logic signed [SAMPLE_W-1:0] osc_a_out_q;
	logic signed [SAMPLE_W-1:0] osc_b_out_q;

	logic [PH_W-1:0]            inc_a;
	logic [PH_W-1:0]            inc_s;
	logic [PH_W-1:0]            cur_ph;
	logic [PH_W-1:0]            cur_inc;
	logic [PH_W-1:0]            ph_nxt;
	wave_kind_t                 kind;
	logic [PH_W-1:0]            blep_p;
	logic                       blep_lt;
	logic                       blep_over;
	logic [PH_W:0]              blep_sum;
	logic [PH_W:0]              blep_rest;
	logic                       blep_sub;
	logic                       div_start;
	logic                       div_done;
	logic [DIV_Q_W-1:0]         div_quot;
	logic [DIV_Q_W-1:0]         blep_d;
	logic [WT_IDX_W-1:0]        wt_i0;
	logic [WT_IDX_W-1:0]        wt_i1;
	logic signed [SAMPLE_W-1:0] wt_w0;
	logic signed [SAMPLE_W-1:0] wt_w1;
	logic signed [SAMPLE_W:0]   wt_diff;
	logic [PH_W-1:0]            wt_fr;
	logic signed [MUL_P_W-1:0]  tbl_bias;
	logic signed [MUL_P_W-1:0]  tbl_tr;
	logic signed [SAMPLE_W-1:0] sub_s;
	logic signed [SAMPLE_W-1:0] osc_val;
	logic signed [SAMPLE_W-1:0] acc_init;
	logic [MUL_P_W-29:0]        incb_full;
	logic signed [39:0]         mix_round;
	logic signed [MUL_A_W-1:0]  mul_a;
	logic signed [MUL_B_W-1:0]  mul_b;
	logic signed [MUL_P_W-1:0]  prod_q;
	logic signed [SAMPLE_W-1:0] rom_data;
	logic                       can_load;

	dopm_mul u_mul (
		.clk    (clk),
		.op_a   (mul_a),
		.op_b   (mul_b),
		.prod_q (prod_q)
	);

	dopm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (blep_lt ? blep_p : blep_rest[PH_W-1:0]),
		.den    (cur_inc),
		.done   (div_done),
		.quot   (div_quot)
	);

	dopm_sine_rom u_rom (
		.clk    (clk),
		.idx    (cur_ph[PH_W-1 -: SINE_IDX_W]),
		.data_q (rom_data)
	);

	// Clamped increments.
	always_comb begin
		if (inc_a_raw_q < INC_LO) begin
			inc_a = INC_LO;
		end else if (inc_a_raw_q > INC_HI) begin
			inc_a = INC_HI;
		end else begin
			inc_a = inc_a_raw_q;
		end
		if ((inc_a_raw_q >> 1) < INC_LO) begin
			inc_s = INC_LO;
		end else if ((inc_a_raw_q >> 1) > INC_S_HI) begin
			inc_s = INC_S_HI;
		end else begin
			inc_s = inc_a_raw_q >> 1;
		end
	end

	assign cur_ph  = osc_sel_q ? phase_b_q : phase_a_q;
	assign cur_inc = osc_sel_q ? inc_b_q : inc_a;
	assign ph_nxt  = cur_ph + cur_inc;

	always_comb begin
		if (!osc_sel_q) begin
			case (wave_a_q)
				WAVE_A_TABLE:  kind = KIND_TABLE;
				WAVE_A_SAW:    kind = KIND_SAW;
				WAVE_A_SQUARE: kind = KIND_SQUARE;
				default:       kind = KIND_SINE;
			endcase
		end else begin
			case (wave_b_q)
				WAVE_B_SAW:    kind = KIND_SAW;
				WAVE_B_SQUARE: kind = KIND_SQUARE;
				WAVE_B_SINE:   kind = KIND_SINE;
				default:       kind = KIND_ZERO;
			endcase
		end
	end

	// The second correction of a square sits half a cycle away.
	assign blep_p    = blep_idx_q ? cur_ph + PH_HALF : cur_ph;
	assign blep_lt   = blep_p < cur_inc;
	assign blep_sum  = {1'b0, blep_p} + {1'b0, cur_inc};
	assign blep_over = blep_sum > PH_FULL;
	assign blep_rest = PH_FULL - {1'b0, blep_p};
	assign blep_sub  = (kind == KIND_SAW) || blep_idx_q;
	assign blep_d    = {1'b1, {(DIV_Q_W-1){1'b0}}} - div_quot;
	assign div_start = (state_q == ST_BLEP) && (blep_lt || blep_over);

	assign wt_i0   = cur_ph[PH_W-1 -: WT_IDX_W];
	assign wt_i1   = wt_i0 + 1'b1;
	assign wt_w0   = $signed(HARM_TABLE[wt_i0]);
	assign wt_w1   = $signed(HARM_TABLE[wt_i1]);
	assign wt_diff = {wt_w1[SAMPLE_W-1], wt_w1} - {wt_w0[SAMPLE_W-1], wt_w0};
	assign wt_fr   = {cur_ph[PH_W-WT_IDX_W-1:0], {WT_IDX_W{1'b0}}};
	// Division by the full phase range truncates toward zero.
	assign tbl_bias = prod_q[MUL_P_W-1] ? MUL_P_W'((1 << PH_W) - 1) : '0;
	assign tbl_tr   = (prod_q + tbl_bias) >>> PH_W;

	assign sub_s = phase_sub_q[PH_W-1] ? 16'sh8000 : 16'sh7FFF;

	always_comb begin
		case (kind)
			KIND_SAW:    acc_init = $signed({~ph_nxt[PH_W-1], ph_nxt[PH_W-2 -: SAMPLE_W-1]});
			KIND_SQUARE: acc_init = ph_nxt[PH_W-1] ? 16'sh8000 : 16'sh7FFF;
			default:     acc_init = '0;
		endcase
	end

	assign osc_val   = (kind == KIND_SINE) ? rom_data : sat16(40'(acc_q));
	assign incb_full = prod_q[MUL_P_W-1:28];
	assign mix_round = (40'(mix_q) + 40'sd16384) >>> 15;
	assign can_load  = !out_valid_q || !out_stall;

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_FM_MUL: begin
				mul_a = MUL_A_W'(fm_q);
				mul_b = {{(MUL_B_W-GAIN_W){1'b0}}, fm_depth_q};
			end
			ST_INCB_MUL: begin
				mul_a = f_q;
				mul_b = {1'b0, inc_b_raw_q};
			end
			ST_TBL_MUL: begin
				mul_a = {{(MUL_A_W-PH_W){1'b0}}, wt_fr};
				mul_b = MUL_B_W'(wt_diff);
			end
			ST_BLEP_MUL: begin
				mul_a = {{(MUL_A_W-DIV_Q_W){1'b0}}, blep_d};
				mul_b = {{(MUL_B_W-DIV_Q_W){1'b0}}, blep_d};
			end
			ST_MIX_A: begin
				mul_a = MUL_A_W'(a_q);
				mul_b = {{(MUL_B_W-GAIN_W){1'b0}}, level_a_q};
			end
			ST_MIX_B: begin
				mul_a = MUL_A_W'(b_q);
				mul_b = {{(MUL_B_W-GAIN_W){1'b0}}, level_b_q};
			end
			ST_MIX_S: begin
				mul_a = MUL_A_W'(sub_s);
				mul_b = {{(MUL_B_W-GAIN_W){1'b0}}, sub_gain_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inc_a_raw_q <= '0;
			inc_b_raw_q <= '0;
			fm_depth_q  <= '0;
			wave_a_q    <= '0;
			wave_b_q    <= '0;
			level_a_q   <= '0;
			level_b_q   <= '0;
			sub_gain_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_INC_A:    inc_a_raw_q <= cfg_data;
				CFG_INC_B:    inc_b_raw_q <= cfg_data;
				CFG_FM_DEPTH: fm_depth_q  <= cfg_data[GAIN_W-1:0];
				CFG_WAVE_A:   wave_a_q    <= cfg_data[1:0];
				CFG_WAVE_B:   wave_b_q    <= cfg_data[1:0];
				CFG_LEVEL_A:  level_a_q   <= cfg_data[GAIN_W-1:0];
				CFG_LEVEL_B:  level_b_q   <= cfg_data[GAIN_W-1:0];
				CFG_SUB_GAIN: sub_gain_q  <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_a_q   <= '0;
			phase_b_q   <= '0;
			phase_sub_q <= '0;
			osc_sel_q   <= 1'b0;
			blep_idx_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// A new result may replace the one taken in the same cycle.
			if (state_q == ST_OUT && can_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						osc_sel_q <= 1'b0;
						state_q   <= ST_FM_MUL;
					end
				end
				ST_FM_MUL:   state_q <= ST_FM_F;
				ST_FM_F:     state_q <= ST_INCB_MUL;
				ST_INCB_MUL: state_q <= (f_q <= 0) ? ST_PH : ST_INCB;
				ST_INCB:     state_q <= ST_PH;
				ST_PH: begin
					blep_idx_q <= 1'b0;
					if (!osc_sel_q) begin
						phase_a_q   <= ph_nxt;
						phase_sub_q <= phase_sub_q + inc_s;
					end else begin
						phase_b_q <= ph_nxt;
					end
					case (kind)
						KIND_TABLE:  state_q <= ST_TBL_MUL;
						KIND_SAW:    state_q <= ST_BLEP;
						KIND_SQUARE: state_q <= ST_BLEP;
						KIND_SINE:   state_q <= ST_SINE;
						default:     state_q <= ST_OSC_DONE;
					endcase
				end
				ST_SINE:    state_q <= ST_OSC_DONE;
				ST_TBL_MUL: state_q <= ST_TBL_FIN;
				ST_TBL_FIN: state_q <= ST_OSC_DONE;
				ST_BLEP: begin
					if (blep_lt || blep_over) begin
						state_q <= ST_DIV;
					end else if (kind == KIND_SQUARE && !blep_idx_q) begin
						blep_idx_q <= 1'b1;
					end else begin
						state_q <= ST_OSC_DONE;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_BLEP_MUL;
					end
				end
				ST_BLEP_MUL: state_q <= ST_BLEP_ACC;
				ST_BLEP_ACC: begin
					if (kind == KIND_SQUARE && !blep_idx_q) begin
						blep_idx_q <= 1'b1;
						state_q    <= ST_BLEP;
					end else begin
						state_q <= ST_OSC_DONE;
					end
				end
				ST_OSC_DONE: begin
					if (!osc_sel_q) begin
						osc_sel_q <= 1'b1;
						state_q   <= ST_PH;
					end else begin
						state_q <= ST_MIX_A;
					end
				end
				ST_MIX_A:   state_q <= ST_MIX_B;
				ST_MIX_B:   state_q <= ST_MIX_S;
				ST_MIX_S:   state_q <= ST_MIX_END;
				ST_MIX_END: state_q <= ST_OUT;
				ST_OUT: begin
					if (can_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					fm_q <= fm_in;
				end
			end
			ST_FM_F: begin
				f_q <= MUL_A_W'(1 << 28) + prod_q[MUL_A_W-1:0];
			end
			ST_INCB_MUL: begin
				if (f_q <= 0) begin
					inc_b_q <= INC_LO;
				end
			end
			ST_INCB: begin
				if (incb_full < INC_LO) begin
					inc_b_q <= INC_LO;
				end else if (incb_full > INC_HI) begin
					inc_b_q <= INC_HI;
				end else begin
					inc_b_q <= incb_full[PH_W-1:0];
				end
			end
			ST_PH: begin
				acc_q <= ACC_W'(acc_init);
			end
			ST_TBL_FIN: begin
				acc_q <= ACC_W'(wt_w0) + tbl_tr[ACC_W-1:0];
			end
			ST_BLEP: begin
				blep_negc_q <= blep_lt ^ blep_sub;
			end
			ST_BLEP_ACC: begin
				if (blep_negc_q) begin
					acc_q <= acc_q - ACC_W'(prod_q[32:18]);
				end else begin
					acc_q <= acc_q + ACC_W'(prod_q[32:18]);
				end
			end
			ST_OSC_DONE: begin
				if (!osc_sel_q) begin
					a_q <= osc_val;
				end else begin
					b_q <= osc_val;
				end
			end
			ST_MIX_B:   mix_q <= prod_q[MIX_W-1:0];
			ST_MIX_S:   mix_q <= mix_q + prod_q[MIX_W-1:0];
			ST_MIX_END: mix_q <= mix_q + prod_q[MIX_W-1:0];
			ST_OUT: begin
				if (can_load) begin
					mix_out_q   <= sat16(mix_round);
					osc_a_out_q <= a_q;
					osc_b_out_q <= b_q;
				end
			end
			default: ;
		endcase
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign mix_out   = mix_out_q;
	assign osc_a_out = osc_a_out_q;
	assign osc_b_out = osc_b_out_q;

endmodule
